### sv/rnd_pkg.sv
// Package for the radix-N digit converter: sizes, codes, request and
// response structs of the divider, and the digit helper functions.
// Depends on nothing; every other file of the block but rnd_ram imports it.
`default_nettype none

package rnd_pkg;

  // Width of the value that is converted. Input bits above it are ignored.
  localparam int unsigned VALUE_BITS = 32;
  // Fixed width of the input field.
  localparam int unsigned IN_BITS = 32;

  // Digit counter holds 0 through VALUE_BITS; digit store address.
  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_STEP_BITS = 8;
  localparam int unsigned DIV_PASSES = (VALUE_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int unsigned DIV_W = DIV_PASSES * DIV_STEP_BITS;
  localparam int unsigned PASS_W = (DIV_PASSES > 1) ? $clog2(DIV_PASSES) : 1;

  localparam int unsigned BASE_W  = 5;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 7;
  // Partial remainder after a shift: 2 * 15 + 1 fits in five bits.
  localparam int unsigned REM_W   = 5;

  localparam logic [BASE_W-1:0]  BASE_RESET = 5'd10;
  localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
  localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A     = 7'h41;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    logic              start;
    value_t            dividend;
    logic [BASE_W-1:0] divisor;
  } rnd_div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    value_t             quotient;
    logic [DIGIT_W-1:0] remainder;
  } rnd_div_rsp_t;

  // Keeps the low VALUE_BITS bits of the input, zero extended if needed.
  function automatic value_t fit_value(input logic [IN_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[VALUE_BITS-1:0];
  endfunction

  // Bases below two act as two, bases above sixteen act as sixteen.
  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) begin
      return BASE_MIN;
    end
    if (b > BASE_MAX) begin
      return BASE_MAX;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
    if (d < DIGIT_TEN) begin
      return CHAR_ZERO + CHAR_W'(d);
    end
    return CHAR_A + CHAR_W'(d - DIGIT_TEN);
  endfunction

endpackage

`default_nettype wire

### sv/rnd_if.sv
// Valid/ready channel interfaces of the radix-N digit converter: input value,
// output digit and base configuration. Depends on rnd_pkg.
`default_nettype none

interface rnd_in_if;
  import rnd_pkg::*;
  logic               valid;
  logic               ready;
  logic [IN_BITS-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rnd_out_if;
  import rnd_pkg::*;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  digit_char;
  logic [DIGIT_W-1:0] digit_value;
  logic               last_digit;
  modport source (output valid, output digit_char, output digit_value,
                  output last_digit, input ready);
  modport sink   (input valid, input digit_char, input digit_value,
                  input last_digit, output ready);
endinterface

interface rnd_cfg_if;
  import rnd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] base;
  modport source (output valid, output base, input ready);
  modport sink   (input valid, input base, output ready);
endinterface

`default_nettype wire

### sv/rnd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module rnd_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/rnd_div.sv
// Iterative divider of a value by a small base (2..16), DIV_STEP_BITS
// quotient bits per cycle, restoring scheme. Depends on rnd_pkg.
`default_nettype none

module rnd_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rnd_pkg::rnd_div_req_t req_i,
  output rnd_pkg::rnd_div_rsp_t rsp_o
);
  import rnd_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [PASS_W-1:0] pass_q;
  logic [DIV_W-1:0]  acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [BASE_W-1:0] dvs_q;
  logic              start;

  assign start = req_i.start && !busy_q;

  // Dividend bits leave the top of acc_q while quotient bits enter at the bottom.
  always_comb begin
    logic [REM_W-1:0]         r;
    logic [REM_W-1:0]         t;
    logic [DIV_STEP_BITS-1:0] qb;
    r  = rem_q;
    qb = '0;
    for (int j = 0; j < DIV_STEP_BITS; j++) begin
      t = {r[DIGIT_W-1:0], acc_q[DIV_W-1-j]};
      if (t >= dvs_q) begin
        r = t - dvs_q;
        qb[DIV_STEP_BITS-1-j] = 1'b1;
      end else begin
        r = t;
      end
    end
    rem_d = r;
    acc_d = (acc_q << DIV_STEP_BITS) | DIV_W'(qb);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      pass_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        busy_q <= 1'b1;
        pass_q <= '0;
      end else if (busy_q) begin
        pass_q <= pass_q + 1'b1;
        if (pass_q == PASS_W'(DIV_PASSES - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      acc_q <= DIV_W'(req_i.dividend);
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = acc_q[VALUE_BITS-1:0];
  assign rsp_o.remainder = rem_q[DIGIT_W-1:0];

  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_rem_below_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below the divisor");

  a_done_after_pass : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q))
    else $error("done without a division in flight");

endmodule

`default_nettype wire

### sv/radix_n_digit_converter.sv
// Top level of the radix-N digit converter: sequencer, base register,
// digit store and output register. Depends on rnd_pkg, rnd_if, rnd_ram, rnd_div.
//
//   Channel     Dir  Payload                              Transfer when
//   in_chan_i   in   value[31:0]                          valid && ready
//   out_chan_o  out  digit_char[6:0], digit_value[3:0],   valid && ready
//                    last_digit
//   cfg_chan_i  in   base[4:0]                            valid && ready (ready tied high)
//
// An item with n digits occupies the block until its last digit is taken. The
// shared divider makes one division per digit, and each digit then passes
// through the digit store read port and the output register. Output stalls
// lengthen the time that an item occupies the block.
// After reset the base is ten and the block is idle and ready.
`default_nettype none

module radix_n_digit_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  rnd_in_if.sink           in_chan_i,
  rnd_out_if.source        out_chan_o,
  rnd_cfg_if.sink          cfg_chan_i
);
  import rnd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for a value
    S_DIV,   // divider in use, one digit per division
    S_RD,    // read the next digit from the store
    S_LOAD,  // store data arrives, load the output register
    S_SEND   // digit offered downstream
  } state_e;

  state_e             state_q;
  logic [BASE_W-1:0]  base_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [ADDR_W-1:0]  rd_idx_q;
  logic               out_valid_q;
  logic [CHAR_W-1:0]  char_q;
  logic [DIGIT_W-1:0] dval_q;
  logic               last_q;

  rnd_div_req_t       div_req;
  rnd_div_rsp_t       div_rsp;

  logic               in_xfer;
  logic               ram_we;
  logic               ram_re;
  logic [DIGIT_W-1:0] ram_rdata;

  assign in_chan_i.ready  = (state_q == S_IDLE);
  assign in_xfer          = in_chan_i.valid && (state_q == S_IDLE);
  assign cfg_chan_i.ready = 1'b1;

  // The divider is started on the transfer of a value and again after
  // every division whose quotient is not yet zero.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = clamp_base(base_q);
    if (in_xfer) begin
      div_req.start    = 1'b1;
      div_req.dividend = fit_value(in_chan_i.value);
    end else if (state_q == S_DIV && div_rsp.done && div_rsp.quotient != '0) begin
      div_req.start = 1'b1;
    end
  end

  rnd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Digits are stored least significant first and read back in reverse.
  assign ram_we = (state_q == S_DIV) && div_rsp.done;
  assign ram_re = (state_q == S_RD);

  rnd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (VALUE_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (div_rsp.remainder),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= BASE_RESET;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      dval_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_chan_i.valid) begin
        base_q <= cfg_chan_i.base;
      end
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            cnt_q <= cnt_q + 1'b1;
            // A zero quotient ends the division; the digit just written
            // is the most significant one.
            if (div_rsp.quotient == '0) begin
              rd_idx_q <= cnt_q[ADDR_W-1:0];
              state_q  <= S_RD;
            end
          end
        end
        S_RD: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          char_q      <= ascii_of(ram_rdata);
          dval_q      <= ram_rdata;
          last_q      <= (rd_idx_q == '0);
          out_valid_q <= 1'b1;
          state_q     <= S_SEND;
        end
        S_SEND: begin
          if (out_chan_o.ready) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              rd_idx_q <= rd_idx_q - 1'b1;
              state_q  <= S_RD;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_chan_o.valid       = out_valid_q;
  assign out_chan_o.digit_char  = char_q;
  assign out_chan_o.digit_value = dval_q;
  assign out_chan_o.last_digit  = last_q;

  a_valid_in_send : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_SEND))
    else $error("output valid outside the send state");

  a_last_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_chan_o.ready && last_q) |=> (state_q == S_IDLE))
    else $error("block not idle after the last digit transfer");

  a_store_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (cnt_q < CNT_W'(VALUE_BITS)))
    else $error("digit store written beyond its depth");

  a_div_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND || state_q == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while no division is expected");

endmodule

`default_nettype wire

### test/rnd_checker.sv
// Checker for the radix-N digit converter: watches the value, base and digit
// channels, predicts the digit sequence and compares each digit transfer.
// Depends on rnd_pkg.
module rnd_checker
  import rnd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [IN_BITS-1:0] in_value_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [BASE_W-1:0]  cfg_base_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [CHAR_W-1:0]  out_digit_char_i,
  input  logic [DIGIT_W-1:0] out_digit_value_i,
  input  logic               out_last_digit_i,
  output int unsigned        mismatches_o,
  output int unsigned        digits_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic [DIGIT_W-1:0] digit_value;
    logic               last_digit;
  } digit_t;

  digit_t            digits_due[$];
  logic [BASE_W-1:0] radix_q;

  // Splits a value into digits by repeated division, then queues them most
  // significant first with the flag on the final one.
  function automatic void queue_digits_of(input logic [IN_BITS-1:0] raw);
    value_t             rest;
    value_t             radix;
    logic [DIGIT_W-1:0] lsd_first[$];
    digit_t             d;
    int                 idx;
    if (radix_q < BASE_MIN) begin
      radix = value_t'(BASE_MIN);
    end else if (radix_q > BASE_MAX) begin
      radix = value_t'(BASE_MAX);
    end else begin
      radix = value_t'(radix_q);
    end
    rest = value_t'(raw);
    do begin
      lsd_first.push_back(DIGIT_W'(rest % radix));
      rest = rest / radix;
    end while (rest != 0);
    for (idx = lsd_first.size() - 1; idx >= 0; idx--) begin
      d.digit_value = lsd_first[idx];
      if (d.digit_value < DIGIT_TEN) begin
        d.digit_char = CHAR_ZERO + CHAR_W'(d.digit_value);
      end else begin
        d.digit_char = CHAR_A + CHAR_W'(d.digit_value - DIGIT_TEN);
      end
      d.last_digit = (idx == 0);
      digits_due.push_back(d);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    digit_t got;
    digit_t want;
    if (!rst_ni) begin
      digits_due.delete();
      radix_q      = BASE_RESET;
      mismatches_o = 0;
    end else begin
      // Digits are checked before a new value is predicted in the same cycle.
      if (out_valid_i && out_ready_i) begin
        got.digit_char  = out_digit_char_i;
        got.digit_value = out_digit_value_i;
        got.last_digit  = out_last_digit_i;
        if (digits_due.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= REPORT_LIMIT) begin
            $display("%0t: unexpected digit: char %02h value %0d last %0b",
                     $realtime, got.digit_char, got.digit_value, got.last_digit);
          end
        end else begin
          want = digits_due.pop_front();
          if (got.digit_char !== want.digit_char || got.digit_value !== want.digit_value ||
              got.last_digit !== want.last_digit) begin
            mismatches_o++;
            if (mismatches_o <= REPORT_LIMIT) begin
              $display("%0t: digit mismatch: expected char %02h value %0d last %0b, got char %02h value %0d last %0b",
                       $realtime, want.digit_char, want.digit_value, want.last_digit,
                       got.digit_char, got.digit_value, got.last_digit);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        radix_q = cfg_base_i;
      end
      if (in_valid_i && in_ready_i) begin
        queue_digits_of(in_value_i);
      end
    end
    digits_pending_o = digits_due.size();
  end

endmodule

### test/tb_radix_n_digit_converter.sv
// Top of the radix-N digit converter testbench: clock, reset, value and base
// stimulus, random output stalls and the verdict.
// Depends on rnd_pkg, rnd_if, the converter RTL and rnd_checker.
module tb_radix_n_digit_converter;
  timeunit 1ns;
  timeprecision 1ps;
  import rnd_pkg::*;

  localparam int unsigned CLK_PERIOD      = 12;
  localparam int unsigned RESET_CYCLES    = 4;
  // Percent of cycles in which either side holds off.
  localparam int unsigned IDLE_PERCENT    = 9;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 24;
  // The phase in which neither side ever holds off.
  localparam int unsigned CALM_PHASE      = 2;
  // A 32-digit value runs all of its divisions with no transfer at all, so the
  // watchdog limit leaves a wide margin over the time that they take.
  localparam int unsigned IDLE_LIMIT      = 4000;
  // Cycles kept open after the last digit so that a stray extra digit shows.
  localparam int unsigned SETTLE_CYCLES   = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   calm   = 1'b0;

  int unsigned mismatches;
  int unsigned digits_pending;

  rnd_in_if  in_chan ();
  rnd_out_if out_chan ();
  rnd_cfg_if cfg_chan ();

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  radix_n_digit_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  rnd_checker checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_chan.valid),
    .in_ready_i        (in_chan.ready),
    .in_value_i        (in_chan.value),
    .cfg_valid_i       (cfg_chan.valid),
    .cfg_ready_i       (cfg_chan.ready),
    .cfg_base_i        (cfg_chan.base),
    .out_valid_i       (out_chan.valid),
    .out_ready_i       (out_chan.ready),
    .out_digit_char_i  (out_chan.digit_char),
    .out_digit_value_i (out_chan.digit_value),
    .out_last_digit_i  (out_chan.last_digit),
    .mismatches_o      (mismatches),
    .digits_pending_o  (digits_pending)
  );

  // The digit receiver stalls in about one cycle of eleven, except during the
  // calm phase. Ready changes only at the falling edge, so the block and the
  // checker both see a settled value at the rising edge.
  initial begin : digit_receiver
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_chan.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // The watchdog counts cycles in which no channel completes a transfer. A
  // hung block or a lost handshake ends the run here.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (cfg_chan.valid && cfg_chan.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("status: fail");
    $finish;
  end

  // Presents one value and returns at the falling edge after its transfer.
  // Valid is left high so that a value that follows at once is not preceded
  // by a dropped cycle; callers lower it before any pause.
  task automatic send_value(input logic [IN_BITS-1:0] v);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_chan.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_chan.valid = 1'b1;
    in_chan.value = v;
    do @(posedge clk_i); while (!in_chan.ready);
    @(negedge clk_i);
  endtask

  // Every value produces at least one digit, so once the checker holds no
  // expected digit the block has finished its last conversion.
  task automatic wait_drained();
    in_chan.valid = 1'b0;
    while (digits_pending != 0) begin
      @(negedge clk_i);
    end
  endtask

  // The base register is only written while the block is idle.
  task automatic set_base(input logic [BASE_W-1:0] b);
    wait_drained();
    cfg_chan.valid = 1'b1;
    cfg_chan.base  = b;
    do @(posedge clk_i); while (!cfg_chan.ready);
    @(negedge clk_i);
    cfg_chan.valid = 1'b0;
  endtask

  // Mixes full-width values, values of random length, small values and values
  // near the top of the range so that every digit count turns up often.
  function automatic logic [IN_BITS-1:0] random_value();
    logic [IN_BITS-1:0] v;
    case ($urandom_range(5))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(IN_BITS - 1);
      2: v = $urandom_range(40);
      3: v = {IN_BITS{1'b1}} >> $urandom_range(IN_BITS - 1);
      4: v = {IN_BITS{1'b1}} - $urandom_range(20);
      default: v = $urandom & $urandom;
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int unsigned       phase;
    int unsigned       n;
    logic [BASE_W-1:0] b;

    in_chan.valid  = 1'b0;
    in_chan.value  = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.base  = BASE_RESET;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part. The first values run with the base left at its reset
    // value of ten: zero, single digits, the first carry and the extremes.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);

    // Base two gives the longest digit string, 32 digits for all ones.
    set_base(BASE_MIN);
    send_value(32'hFFFF_FFFF);
    send_value(32'd0);
    send_value(32'd1);

    // Base sixteen brings out every letter digit.
    set_base(BASE_MAX);
    send_value(32'hFEDC_BA98);
    send_value(32'h7654_3210);

    // Bases below two must behave as base two.
    set_base(5'd0);
    send_value(32'd5);
    send_value(32'hFFFF_FFFF);
    set_base(5'd1);
    send_value(32'd6);

    // Bases above sixteen must behave as base sixteen.
    set_base(5'd31);
    send_value(32'hDEAD_BEEF);
    set_base(5'd17);
    send_value(32'h00AB_CDEF);

    // Odd bases, where no digit boundary lines up with the value's bits.
    set_base(5'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'd0);
    set_base(5'd15);
    send_value(32'hFFFF_FFFF);

    // Random part: each phase runs under one base. The first phases cover the
    // extremes, base ten and the out-of-range bases; the rest pick any five-bit value.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: b = BASE_MIN;
        1: b = BASE_MAX;
        2: b = BASE_RESET;
        3: b = 5'd31;
        4: b = 5'd0;
        default: b = BASE_W'($urandom_range(31));
      endcase
      set_base(b);
      calm = (phase == CALM_PHASE);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_value(random_value());
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && digits_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
